// ----- hw/rtl/hpt_pkg.sv -----
`timescale 1ns / 1ps

package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS = 8;
  localparam int NUM_LANES = 4;

  typedef logic signed [31:0] fix_t;
  typedef fix_t [3:0] vec4_t;
  // mat_t[column][row], columns I J K T
  typedef vec4_t [3:0] mat_t;

  typedef enum logic [2:0] {
    KIND_VEC2  = 3'd0,
    KIND_POS2  = 3'd1,
    KIND_VEC3  = 3'd2,
    KIND_POS3  = 3'd3,
    KIND_HOMOG = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_COL_I_XY = 3'd0,
    REG_COL_I_ZW = 3'd1,
    REG_COL_J_XY = 3'd2,
    REG_COL_J_ZW = 3'd3,
    REG_COL_K_XY = 3'd4,
    REG_COL_K_ZW = 3'd5,
    REG_COL_T_XY = 3'd6,
    REG_COL_T_ZW = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } lane_ctl_t;

endpackage

// ----- hw/rtl/hpt_in_if.sv -----
`timescale 1ns / 1ps

interface hpt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (output valid, kind, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, kind, in_x, in_y, in_z, in_w, output ready);
endinterface

// ----- hw/rtl/hpt_out_if.sv -----
`timescale 1ns / 1ps

interface hpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               overflow;

  modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

// ----- hw/rtl/hpt_regs.sv -----
`timescale 1ns / 1ps

module hpt_regs #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output hpt_pkg::mat_t mat
);

  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [hpt_pkg::NUM_REGS-1:0][63:0] regs;
  logic [2:0]                         idx;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[hpt_pkg::REG_COL_I_XY] <= ONE;
      regs[hpt_pkg::REG_COL_I_ZW] <= '0;
      regs[hpt_pkg::REG_COL_J_XY] <= ONE << 32;
      regs[hpt_pkg::REG_COL_J_ZW] <= '0;
      regs[hpt_pkg::REG_COL_K_XY] <= '0;
      regs[hpt_pkg::REG_COL_K_ZW] <= ONE;
      regs[hpt_pkg::REG_COL_T_XY] <= '0;
      regs[hpt_pkg::REG_COL_T_ZW] <= ONE << 32;
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata;
    end
  end

  // each pair of registers holds one column: x, y, z, w from low to high
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mat[c][0] = regs[2*c][31:0];
      mat[c][1] = regs[2*c][63:32];
      mat[c][2] = regs[2*c+1][31:0];
      mat[c][3] = regs[2*c+1][63:32];
    end
  end

endmodule

// ----- hw/rtl/hpt_lane.sv -----
`timescale 1ns / 1ps

module hpt_lane #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  hpt_pkg::lane_ctl_t  ctl,
  input  hpt_pkg::vec4_t      m_row,
  input  hpt_pkg::vec4_t      vec,
  output hpt_pkg::fix_t       sum,
  output logic                ovf
);

  localparam int SUM_W = 64 - FRAC_BITS + 3;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(64'shFFFF_FFFF_8000_0000);

  logic signed [63:0]      prod [4];
  logic signed [SUM_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      for (int c = 0; c < 4; c++) begin
        prod[c] <= 64'(m_row[c]) * 64'(vec[c]);
      end
    end
  end

  // floor-truncate each product, add at full width
  always_comb begin
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      acc = acc + SUM_W'(prod[c] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      priority if (acc > SAT_MAX) begin
        sum <= SAT_MAX[31:0];
        ovf <= 1'b1;
      end else if (acc < SAT_MIN) begin
        sum <= SAT_MIN[31:0];
        ovf <= 1'b1;
      end else begin
        sum <= acc[31:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/homogeneous_point_transform_core.sv -----
`timescale 1ns / 1ps

// Homogeneous point transform: multiplies the 4x4 matrix held in the APB
// registers (columns I, J, K, T; two Q entries per 64-bit register) by one
// coordinate per item, in the mode picked by kind.
// Channels: coord takes kind and in_x..in_w; result gives out_x..out_w and
// overflow. Both use valid/ready; an item moves when both are high.
// Between accept on coord and valid on result the item passes the product
// register, the per-row sum/saturate register and the output register.
// Throughput: one item per cycle unless result stalls; four row lanes each
// run four 32x32 multipliers in parallel, so nothing is shared between items.
// Stall: each stage holds while the one after it is full and blocked, so
// up to three items sit in flight while result.ready is low; coord.ready
// drops only once every stage is full.
// Reset (rst, synchronous): pipeline empties and the matrix returns to
// identity. Write the registers only while no item is in flight.
module homogeneous_point_transform_core #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hpt_in_if.sink      coord,
  hpt_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic signed [31:0] ONE = 32'(1) << FRAC_BITS;

  hpt_pkg::mat_t      mat;
  hpt_pkg::vec4_t     vec;
  hpt_pkg::vec4_t     m_row [hpt_pkg::NUM_LANES];
  hpt_pkg::fix_t      lane_sum [hpt_pkg::NUM_LANES];
  logic [3:0]         lane_ovf;
  hpt_pkg::lane_ctl_t ctl;

  logic       v1, v2, v3;
  logic       rdy1, rdy2, rdy3;
  logic [2:0] kind1, kind2;
  logic [3:0] row_en;
  logic       is_3d, is_pos, is_homog;

  hpt_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mat     (mat)
  );

  // stage ready: a stage can load when empty or when it drains this cycle
  assign rdy3 = !v3 || result.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign coord.ready = rdy1;

  assign ctl.load_prod = rdy1 && coord.valid;
  assign ctl.load_sum  = rdy2 && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= coord.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // missing components are zero; w is one for positions
  always_comb begin
    is_homog = (coord.kind == hpt_pkg::KIND_HOMOG);
    is_pos   = (coord.kind == hpt_pkg::KIND_POS2) || (coord.kind == hpt_pkg::KIND_POS3);
    is_3d    = (coord.kind == hpt_pkg::KIND_VEC3) || (coord.kind == hpt_pkg::KIND_POS3) ||
               is_homog;
    vec[0] = coord.in_x;
    vec[1] = coord.in_y;
    vec[2] = is_3d ? coord.in_z : '0;
    vec[3] = is_homog ? coord.in_w : (is_pos ? ONE : '0);
  end

  always_comb begin
    for (int r = 0; r < hpt_pkg::NUM_LANES; r++) begin
      for (int c = 0; c < 4; c++) begin
        m_row[r][c] = mat[c][r];
      end
    end
  end

  for (genvar r = 0; r < hpt_pkg::NUM_LANES; r++) begin : g_lane
    hpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .m_row (m_row[r]),
      .vec   (vec),
      .sum   (lane_sum[r]),
      .ovf   (lane_ovf[r])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) kind1 <= coord.kind;
    if (ctl.load_sum)  kind2 <= kind1;
  end

  // rows beyond the mode, and unknown kinds, read as zero
  always_comb begin
    row_en[0] = (kind2 <= hpt_pkg::KIND_HOMOG);
    row_en[1] = row_en[0];
    row_en[2] = (kind2 == hpt_pkg::KIND_VEC3) || (kind2 == hpt_pkg::KIND_POS3) ||
                (kind2 == hpt_pkg::KIND_HOMOG);
    row_en[3] = (kind2 == hpt_pkg::KIND_HOMOG);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      result.out_x    <= row_en[0] ? lane_sum[0] : '0;
      result.out_y    <= row_en[1] ? lane_sum[1] : '0;
      result.out_z    <= row_en[2] ? lane_sum[2] : '0;
      result.out_w    <= row_en[3] ? lane_sum[3] : '0;
      result.overflow <= |(row_en & lane_ovf);
    end
  end

  assign result.valid = v3;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    coord.valid && coord.ready |=> v1)
    else $error("accepted item did not enter the product stage");

  a_ovf_clipped: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |->
      result.out_x == 32'sh7FFF_FFFF || result.out_x == 32'sh8000_0000 ||
      result.out_y == 32'sh7FFF_FFFF || result.out_y == 32'sh8000_0000 ||
      result.out_z == 32'sh7FFF_FFFF || result.out_z == 32'sh8000_0000 ||
      result.out_w == 32'sh7FFF_FFFF || result.out_w == 32'sh8000_0000)
    else $error("overflow set with no saturated output");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    v2 && v3 && !result.ready |=> v2 && v3)
    else $error("item lost while output stalled");
`endif

endmodule
